// ===== rtl/rpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes for the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

   localparam int PAGE_BITS      = 10;
   localparam int COUNT_OUT_BITS = 8;
   localparam int STATUS_BITS    = 3;
   localparam int OPCODE_BITS    = 2;

   typedef logic [PAGE_BITS-1:0]      page_type;
   typedef logic [COUNT_OUT_BITS-1:0] count_out_type;
   typedef logic [STATUS_BITS-1:0]    status_type;
   typedef logic [OPCODE_BITS-1:0]    opcode_type;

   localparam opcode_type OP_INIT   = 2'd0;
   localparam opcode_type OP_ALLOC  = 2'd1;
   localparam opcode_type OP_FREE   = 2'd2;
   localparam opcode_type OP_ADDREF = 2'd3;

   localparam status_type STATUS_OK    = 3'd0;
   localparam status_type STATUS_OOM   = 3'd1;
   localparam status_type STATUS_RANGE = 3'd2;
   localparam status_type STATUS_ZERO  = 3'd3;
   localparam status_type STATUS_OVF   = 3'd4;

   // commands to the free stack
   typedef struct packed {
      logic rd_top;
      logic pop;
      logic push;
      logic load;
      logic set_fill;
   } stack_cmd_type;

   // flags derived from the count read out of memory
   typedef struct packed {
      logic zero;
      logic full;
   } count_flags_type;

endpackage

// ===== rtl/rpa_channels.sv =====
// ----------------------------------------------------------------------------
// rpa channels
// Valid/ready channels for requests, responses and the control register.
// ----------------------------------------------------------------------------
interface rpa_req_if;
   import rpa_pkg::*;
   logic       valid;
   logic       ready;
   opcode_type opcode;
   page_type   page_number;
   modport source (output valid, output opcode, output page_number, input ready);
   modport sink   (input valid, input opcode, input page_number, output ready);
endinterface

interface rpa_rsp_if;
   import rpa_pkg::*;
   logic          valid;
   logic          ready;
   page_type      page_out;
   logic          page_valid;
   logic          released;
   status_type    status;
   count_out_type count_after;
   modport source (output valid, output page_out, output page_valid, output released,
                   output status, output count_after, input ready);
   modport sink   (input valid, input page_out, input page_valid, input released,
                   input status, input count_after, output ready);
endinterface

interface rpa_csr_if;
   import rpa_pkg::*;
   logic     valid;
   logic     ready;
   page_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rpa_ref_counts.sv =====
// ----------------------------------------------------------------------------
// rpa_ref_counts
// Reference count memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module rpa_ref_counts #(
   parameter int PAGE_COUNT = 1024,
   parameter int COUNT_BITS = 8,
   parameter int ADDR_BITS  = $clog2(PAGE_COUNT)
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [ADDR_BITS-1:0]           rd_addr,
   input  logic                           wr_en,
   input  logic [ADDR_BITS-1:0]           wr_addr,
   input  logic [COUNT_BITS-1:0]          wr_data,
   output logic [COUNT_BITS-1:0]          rd_count,
   output rpa_pkg::count_flags_type       rd_flags
);
   import rpa_pkg::*;

   logic [COUNT_BITS-1:0] mem [PAGE_COUNT];
   logic [COUNT_BITS-1:0] rd_count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_count_ff <= mem[rd_addr];
      end
   end

   assign rd_count      = rd_count_ff;
   assign rd_flags.zero = (rd_count_ff == '0);
   assign rd_flags.full = (rd_count_ff == '1);

endmodule

// ===== rtl/rpa_free_stack.sv =====
// ----------------------------------------------------------------------------
// rpa_free_stack
// LIFO of free page numbers with its fill level, registered top read.
// ----------------------------------------------------------------------------
module rpa_free_stack #(
   parameter int PAGE_COUNT = 1024,
   parameter int ADDR_BITS  = $clog2(PAGE_COUNT),
   parameter int FILL_BITS  = $clog2(PAGE_COUNT + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rpa_pkg::stack_cmd_type cmd,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  logic [ADDR_BITS-1:0]   wr_data,
   input  logic [FILL_BITS-1:0]   fill_value,
   output logic [ADDR_BITS-1:0]   top_page,
   output logic [FILL_BITS-1:0]   fill
);
   import rpa_pkg::*;

   logic [ADDR_BITS-1:0] mem [PAGE_COUNT];
   logic [ADDR_BITS-1:0] top_ff;
   logic [FILL_BITS-1:0] fill_ff;
   logic [FILL_BITS-1:0] fill_in;
   logic [FILL_BITS-1:0] top_idx;

   assign top_idx = fill_ff - FILL_BITS'(1);

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[fill_ff[ADDR_BITS-1:0]] <= wr_data;
      end else if (cmd.load) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_top) begin
         top_ff <= mem[top_idx[ADDR_BITS-1:0]];
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.set_fill) begin
         fill_in = fill_value;
      end else if (cmd.push) begin
         fill_in = fill_ff + FILL_BITS'(1);
      end else if (cmd.pop) begin
         fill_in = fill_ff - FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign top_page = top_ff;
   assign fill     = fill_ff;

endmodule

// ===== rtl/refcounted_page_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Free-stack page allocator with a reference count per page.
// ----------------------------------------------------------------------------
// For allocate, free and add-reference the item is accepted and both memories
// are read in the idle state, then the execute state checks the count or stack
// level and writes back, so one item is worked on at a time. The result sits
// in an output register; a stalled response holds the block in its write-back
// cycle. Init sweeps the count memory and the stack one page a cycle. After
// reset the count memory is cleared in a pass over every page, during which
// req_ch.ready is low; the control register can be written at any time the
// block is idle.
module refcounted_page_allocator #(
   parameter int PAGE_COUNT = 1024,
   parameter int COUNT_BITS = 8
) (
   input logic       clock,
   input logic       reset,
   rpa_req_if.sink   req_ch,
   rpa_rsp_if.source rsp_ch,
   rpa_csr_if.sink   csr_ch
);
   import rpa_pkg::*;

   localparam int AW = $clog2(PAGE_COUNT);
   localparam int FW = $clog2(PAGE_COUNT + 1);
   localparam int XW = ((AW > PAGE_BITS) ? AW : PAGE_BITS) + 1;
   localparam logic [XW-1:0] PAGE_LIMIT = XW'(PAGE_COUNT);
   localparam logic [AW-1:0] LAST_PAGE  = AW'(PAGE_COUNT - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_INIT  = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [AW-1:0]   sweep_ff, sweep_in;
   opcode_type      op_ff;
   page_type        page_ff;
   page_type        first_page_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   page_type        page_out_ff;
   logic            page_valid_ff;
   logic            released_ff;
   status_type      status_ff;
   count_out_type   count_after_ff;

   page_type        res_page;
   logic            res_valid;
   logic            res_released;
   status_type      res_status;
   count_out_type   res_count;

   logic            req_fire;
   logic            out_free;
   logic            exec_fire;
   logic            sweep_last;

   logic [XW-1:0]   page_x, fp_x, sweep_x, top_x;

   logic                  cnt_wr_en;
   logic [AW-1:0]         cnt_wr_addr;
   logic [COUNT_BITS-1:0] cnt_wr_data;
   logic [COUNT_BITS-1:0] cnt_rd;
   count_flags_type       cnt_flags;

   stack_cmd_type   stk_cmd;
   logic [AW-1:0]   stk_wr_addr;
   logic [AW-1:0]   stk_wr_data;
   logic [FW-1:0]   stk_fill_value;
   logic [AW-1:0]   stk_top;
   logic [FW-1:0]   stk_fill;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign exec_fire    = (state_ff == S_EXEC) && out_free;
   assign sweep_last   = (sweep_ff == LAST_PAGE);

   assign page_x  = XW'(page_ff);
   assign fp_x    = XW'(first_page_ff);
   assign sweep_x = XW'(sweep_ff);
   assign top_x   = XW'(stk_top);

   // pages first_page .. PAGE_COUNT-1 are on the stack after init
   assign stk_fill_value = (fp_x < PAGE_LIMIT) ? FW'(PAGE_LIMIT - fp_x) : '0;

   rpa_ref_counts #(
      .PAGE_COUNT (PAGE_COUNT),
      .COUNT_BITS (COUNT_BITS),
      .ADDR_BITS  (AW)
   ) u_ref_counts (
      .clock    (clock),
      .rd_en    (req_fire),
      .rd_addr  (AW'(req_ch.page_number)),
      .wr_en    (cnt_wr_en),
      .wr_addr  (cnt_wr_addr),
      .wr_data  (cnt_wr_data),
      .rd_count (cnt_rd),
      .rd_flags (cnt_flags)
   );

   rpa_free_stack #(
      .PAGE_COUNT (PAGE_COUNT),
      .ADDR_BITS  (AW),
      .FILL_BITS  (FW)
   ) u_free_stack (
      .clock      (clock),
      .reset      (reset),
      .cmd        (stk_cmd),
      .wr_addr    (stk_wr_addr),
      .wr_data    (stk_wr_data),
      .fill_value (stk_fill_value),
      .top_page   (stk_top),
      .fill       (stk_fill)
   );

   always_comb begin
      cnt_wr_en        = 1'b0;
      cnt_wr_addr      = sweep_ff;
      cnt_wr_data      = '0;
      stk_cmd          = '0;
      stk_cmd.rd_top   = req_fire;
      stk_cmd.set_fill = req_fire && (req_ch.opcode == OP_INIT);
      stk_wr_addr      = AW'(sweep_x - fp_x);
      stk_wr_data      = sweep_ff;
      res_page         = '0;
      res_valid        = 1'b0;
      res_released     = 1'b0;
      res_status       = STATUS_OK;
      res_count        = '0;
      case (state_ff)
         S_CLEAR: begin
            cnt_wr_en = 1'b1;
         end
         S_INIT: begin
            cnt_wr_en    = 1'b1;
            stk_cmd.load = (sweep_x >= fp_x);
         end
         S_EXEC: begin
            case (op_ff)
               OP_ALLOC: begin
                  if (stk_fill == '0) begin
                     res_status = STATUS_OOM;
                  end else begin
                     stk_cmd.pop = exec_fire;
                     cnt_wr_en   = exec_fire && (top_x < PAGE_LIMIT);
                     cnt_wr_addr = stk_top;
                     cnt_wr_data = COUNT_BITS'(1);
                     res_page    = PAGE_BITS'(stk_top);
                     res_valid   = 1'b1;
                     res_count   = COUNT_OUT_BITS'(1);
                  end
               end
               OP_FREE: begin
                  if (page_x < fp_x || page_x >= PAGE_LIMIT) begin
                     res_status = STATUS_RANGE;
                  end else if (cnt_flags.zero) begin
                     res_status = STATUS_ZERO;
                  end else begin
                     cnt_wr_en   = exec_fire;
                     cnt_wr_addr = AW'(page_ff);
                     cnt_wr_data = cnt_rd - COUNT_BITS'(1);
                     stk_wr_data = AW'(page_ff);
                     // last reference gone: page goes back unless the stack is full
                     if (cnt_rd == COUNT_BITS'(1) && XW'(stk_fill) < PAGE_LIMIT) begin
                        stk_cmd.push = exec_fire;
                        res_released = 1'b1;
                     end else begin
                        res_count = COUNT_OUT_BITS'(cnt_rd - COUNT_BITS'(1));
                     end
                  end
               end
               OP_ADDREF: begin
                  if (page_x >= PAGE_LIMIT) begin
                     res_status = STATUS_RANGE;
                  end else if (cnt_flags.zero) begin
                     res_status = STATUS_ZERO;
                  end else if (cnt_flags.full) begin
                     res_status = STATUS_OVF;
                     res_count  = COUNT_OUT_BITS'(cnt_rd);
                  end else begin
                     cnt_wr_en   = exec_fire;
                     cnt_wr_addr = AW'(page_ff);
                     cnt_wr_data = cnt_rd + COUNT_BITS'(1);
                     res_count   = COUNT_OUT_BITS'(cnt_rd + COUNT_BITS'(1));
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      case (state_ff)
         S_CLEAR: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            sweep_in = '0;
            if (req_fire) begin
               state_in = (req_ch.opcode == OP_INIT) ? S_INIT : S_EXEC;
            end
         end
         S_INIT: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_last) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         sweep_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         first_page_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            first_page_ff <= csr_ch.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_ch.opcode;
         page_ff <= req_ch.page_number;
      end
      if (exec_fire) begin
         page_out_ff    <= res_page;
         page_valid_ff  <= res_valid;
         released_ff    <= res_released;
         status_ff      <= res_status;
         count_after_ff <= res_count;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.page_out    = page_out_ff;
   assign rsp_ch.page_valid  = page_valid_ff;
   assign rsp_ch.released    = released_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.count_after = count_after_ff;

endmodule

// ===== rtl/rpa_checker.sv =====
// ----------------------------------------------------------------------------
// rpa_checker
// Port-level checks on the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rpa_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rpa_pkg::page_type      rsp_page_out,
   input logic                   rsp_page_valid,
   input logic                   rsp_released,
   input rpa_pkg::status_type    rsp_status,
   input rpa_pkg::count_out_type rsp_count_after
);
   import rpa_pkg::*;

   // count memory is being cleared right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request side ready right after reset");

   // one item in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                     && $stable(rsp_page_out)))
      else $error("stalled response changed");

   a_alloc_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_page_valid) |-> (rsp_status == STATUS_OK && !rsp_released
                                         && rsp_count_after == COUNT_OUT_BITS'(1)))
      else $error("allocated page with inconsistent status or count");

   a_release_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_released) |-> (rsp_status == STATUS_OK && !rsp_page_valid
                                       && rsp_count_after == '0 && rsp_page_out == '0))
      else $error("released page with inconsistent fields");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_page_out    (rsp_ch.page_out),
   .rsp_page_valid  (rsp_ch.page_valid),
   .rsp_released    (rsp_ch.released),
   .rsp_status      (rsp_ch.status),
   .rsp_count_after (rsp_ch.count_after)
);
